[hw/rtl/imuli_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuli_pkg: shared types and constants
// Item layouts, sizes and operation codes of the IMU interpolation resampler.
// ----------------------------------------------------------------------------
package imuli_pkg;

    localparam int DEPTH     = 256;
    localparam int FRAC_BITS = 16;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int FW        = $clog2(FRAC_BITS + 1);

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_OLD = 2'd1;
    localparam logic [1:0] ST_NO_NEW = 2'd2;
    localparam logic [1:0] ST_FRAC   = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [47:0]        stamp;
        logic signed [31:0] gyro_x;
        logic signed [31:0] gyro_y;
        logic signed [31:0] gyro_z;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic signed [31:0] acc_out_x;
        logic signed [31:0] acc_out_y;
        logic signed [31:0] acc_out_z;
        logic [1:0]         status;
        logic               overflowed;
    } t_out_item;

    typedef struct packed {
        logic [47:0] stamp;
        logic [5:0][31:0] vals;
    } t_entry;

endpackage

[hw/rtl/imuli_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuli_store: sample memory
// One write port and one registered read port for timestamp and six values.
// ----------------------------------------------------------------------------
module imuli_store
    import imuli_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/imuli_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuli_alu: shared datapath
// One subtract/compare per cycle for the restoring divide, one 33x17 multiply
// per cycle for the interpolation lanes, with the rounding shift behind it.
// ----------------------------------------------------------------------------
module imuli_alu
    import imuli_pkg::*;
(
    input  logic [48:0]        i_a,
    input  logic [48:0]        i_b,
    output logic [48:0]        o_diff,
    output logic               o_ge,
    input  logic signed [31:0] i_w0,
    input  logic signed [31:0] i_w1,
    input  logic [FRAC_BITS:0] i_frac,
    output logic [31:0]        o_lerp
);

    logic signed [32:0]             w_delta;
    logic signed [FRAC_BITS+33:0]   w_prod;
    logic signed [FRAC_BITS+33:0]   w_shift;

    assign o_diff = i_a - i_b;
    assign o_ge   = i_a >= i_b;

    assign w_delta = 33'(i_w1) - 33'(i_w0);
    assign w_prod  = (FRAC_BITS+34)'(w_delta) * $signed({1'b0, i_frac});
    // arithmetic shift floors, rounding toward -inf
    assign w_shift = w_prod >>> FRAC_BITS;
    assign o_lerp  = 32'(i_w0) + w_shift[31:0];

endmodule

[hw/rtl/imu_linear_interp_resampler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_linear_interp_resampler_core: IMU linear interpolation resampler
// Loads a batch of samples newest first, then interpolates gyro and accel
// at descending query stamps between the bracketing stored samples.
// ----------------------------------------------------------------------------
// channel | direction | payload    | handshake
// in      | input     | t_in_item  | i_in_valid / o_in_stall
// out     | output    | t_out_item | o_out_valid / i_out_stall
//
// Loads are taken in IDLE and may follow back to back. A query walks the
// entries (WREAD, WCMP) to the stop entry, fetches the bracketing pair
// (ROLD, RNEW), checks the range (CHK, CHK2), runs FRAC_BITS divide steps on
// the shared subtractor, interpolates the lanes on the shared multiplier and
// presents the result in OUT; a failed check goes to OUT with its status.
// Reset clears count, pointer and drop flag. The input stalls while an item
// is at work or a result waits for the output.
// ----------------------------------------------------------------------------
module imu_linear_interp_resampler_core
    import imuli_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WREAD = 4'd1;
    localparam logic [3:0] S_WCMP  = 4'd2;
    localparam logic [3:0] S_ROLD  = 4'd3;
    localparam logic [3:0] S_RNEW  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_CHK2  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_LERP  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]  r_state;
    logic [CW-1:0] r_count, r_ptr;
    logic        r_drop;
    logic [47:0] r_q;
    t_entry      r_old, r_new;
    logic [48:0] r_num, r_den, r_rem;
    logic [FRAC_BITS:0] r_frac;
    logic [FW-1:0] r_step;
    logic [2:0]  r_lane;
    logic [5:0][31:0] r_res;
    logic [1:0]  r_status;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    t_entry        w_wdata, w_rdata;
    logic [48:0]   w_a, w_b, w_diff;
    logic          w_ge;
    logic [31:0]   w_lerp;
    logic          w_acc;
    logic [58:0]   w_num1000;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == S_OUT);
    assign o_out = '{rate_x: r_res[0], rate_y: r_res[1], rate_z: r_res[2],
                     acc_out_x: r_res[3], acc_out_y: r_res[4], acc_out_z: r_res[5],
                     status: r_status, overflowed: r_drop};

    assign w_wdata = '{stamp: i_in.stamp,
                       vals: {i_in.gyro_x, i_in.gyro_y, i_in.gyro_z,
                              i_in.accel_x, i_in.accel_y, i_in.accel_z}};
    assign w_we = w_acc && ((i_in.op == OP_START) ||
                  (i_in.op == OP_APPEND && r_count < CW'(DEPTH)));
    assign w_waddr = (i_in.op == OP_START) ? '0 : r_count[AW-1:0];
    assign w_raddr = (r_state == S_ROLD) ? r_ptr[AW-1:0] - AW'(1) : r_ptr[AW-1:0];

    imuli_store u_store (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // subtractor operands: den = new - old in CHK, divide step otherwise
    always_comb begin
        if (r_state == S_CHK) begin
            w_a = {1'b0, r_new.stamp};
            w_b = {1'b0, r_old.stamp};
        end else begin
            w_a = {r_rem[47:0], 1'b0};
            w_b = r_den;
        end
    end

    // vals packed gyro_x at the top: lane k is index 5-k
    imuli_alu u_alu (
        .i_a(w_a), .i_b(w_b), .o_diff(w_diff), .o_ge(w_ge),
        .i_w0(r_old.vals[3'd5 - r_lane]), .i_w1(r_new.vals[3'd5 - r_lane]),
        .i_frac(r_frac), .o_lerp(w_lerp)
    );

    // num * 1000 as 1024 - 16 - 8
    assign w_num1000 = (59'(r_num) << 10) - (59'(r_num) << 4) - (59'(r_num) << 3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
            r_drop  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_in.op == OP_START) begin
                            r_count <= CW'(1);
                            r_ptr   <= '0;
                            r_drop  <= 1'b0;
                        end else if (i_in.op == OP_APPEND) begin
                            if (r_count < CW'(DEPTH)) r_count <= r_count + CW'(1);
                            else r_drop <= 1'b1;
                        end else if (i_in.op == OP_QUERY) begin
                            r_q <= i_in.stamp;
                            if (r_ptr > r_count) r_ptr <= r_count;
                            r_state <= S_WREAD;
                        end
                    end
                end
                S_WREAD: begin
                    if (r_ptr >= r_count) begin
                        r_status <= ST_NO_OLD;
                        r_res    <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_WCMP;
                    end
                end
                S_WCMP: begin
                    if (w_rdata.stamp > r_q) begin
                        r_ptr   <= r_ptr + CW'(1);
                        r_state <= S_WREAD;
                    end else if (r_ptr == '0) begin
                        r_status <= ST_NO_NEW;
                        r_res    <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_old   <= w_rdata;
                        r_num   <= {1'b0, r_q - w_rdata.stamp};
                        r_state <= S_ROLD;
                    end
                end
                S_ROLD: r_state <= S_RNEW;
                S_RNEW: begin
                    r_new   <= w_rdata;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_den <= w_diff;
                    if (r_new.stamp > r_old.stamp) begin
                        r_state <= S_CHK2;
                    end else begin
                        r_status <= ST_FRAC;
                        r_res    <= '0;
                        r_state  <= S_OUT;
                    end
                end
                S_CHK2: begin
                    if (w_num1000 > 59'(r_den) && r_num <= r_den) begin
                        r_rem  <= r_num;
                        r_step <= '0;
                        if (r_num == r_den) begin
                            r_frac  <= (FRAC_BITS+1)'(1) << FRAC_BITS;
                            r_lane  <= '0;
                            r_state <= S_LERP;
                        end else begin
                            r_frac  <= '0;
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_status <= ST_FRAC;
                        r_res    <= '0;
                        r_state  <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_ge) r_rem <= w_diff;
                    else r_rem <= {r_rem[47:0], 1'b0};
                    r_frac <= {r_frac[FRAC_BITS-1:0], w_ge};
                    r_step <= r_step + FW'(1);
                    if (r_step == FW'(FRAC_BITS - 1)) begin
                        r_lane  <= '0;
                        r_state <= S_LERP;
                    end
                end
                S_LERP: begin
                    r_res[r_lane] <= w_lerp;
                    r_lane <= r_lane + 3'd1;
                    if (r_lane == 3'd5) begin
                        r_status <= ST_OK;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: IMU linear interpolation resampler testbench
// Loads sample batches newest first and sends descending query stamps, with
// some noise. A scoreboard predicts each interpolated result and checks the
// block's output field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb
    import imuli_pkg::*;
;

    class resample_scoreboard;
        logic [47:0]        stamps[DEPTH];
        logic signed [31:0] vals[DEPTH][6];
        int                 count;
        int                 walk;
        bit                 dropped;
        t_out_item          pending[$];
        int                 errors;

        function new();
            count   = 0;
            walk    = 0;
            dropped = 0;
            errors  = 0;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        function void store(int idx, t_in_item it);
            stamps[idx]  = it.stamp;
            vals[idx][0] = it.gyro_x;
            vals[idx][1] = it.gyro_y;
            vals[idx][2] = it.gyro_z;
            vals[idx][3] = it.accel_x;
            vals[idx][4] = it.accel_y;
            vals[idx][5] = it.accel_z;
        endfunction

        function void note_input(t_in_item it);
            t_out_item          r;
            int                 j;
            logic [47:0]        t0, t1, num, den;
            logic [63:0]        frac, rem;
            longint             p;
            logic signed [31:0] lane[6];
            r = '0;
            for (int k = 0; k < 6; k++) lane[k] = '0;
            case (it.op)
                OP_START: begin
                    count   = 0;
                    walk    = 0;
                    dropped = 0;
                    store(0, it);
                    count   = 1;
                end
                OP_APPEND: begin
                    if (count < DEPTH) begin
                        store(count, it);
                        count++;
                    end else begin
                        dropped = 1;
                    end
                end
                OP_QUERY: begin
                    j = (walk > count) ? count : walk;
                    while (j < count && stamps[j] > it.stamp) j++;
                    walk = j;
                    if (j >= count) begin
                        r.status = ST_NO_OLD;
                    end else if (j == 0) begin
                        r.status = ST_NO_NEW;
                    end else begin
                        t0  = stamps[j];
                        t1  = stamps[j - 1];
                        num = it.stamp - t0;
                        den = t1 - t0;
                        if (t1 <= t0 || !(64'(num) * 64'd1000 > 64'(den) && num <= den)) begin
                            r.status = ST_FRAC;
                        end else begin
                            r.status = ST_OK;
                            if (num >= den) begin
                                frac = 64'd1 << FRAC_BITS;
                            end else begin
                                frac = 0;
                                rem  = 64'(num);
                                for (int b = 0; b < FRAC_BITS; b++) begin
                                    rem  = rem << 1;
                                    frac = frac << 1;
                                    if (rem >= 64'(den)) begin
                                        rem  = rem - 64'(den);
                                        frac = frac | 64'd1;
                                    end
                                end
                            end
                            for (int k = 0; k < 6; k++) begin
                                p = (longint'(vals[j - 1][k]) - longint'(vals[j][k]))
                                    * longint'(frac);
                                lane[k] = vals[j][k] + 32'(p >>> FRAC_BITS);
                            end
                        end
                    end
                    r.rate_x     = lane[0];
                    r.rate_y     = lane[1];
                    r.rate_z     = lane[2];
                    r.acc_out_x  = lane[3];
                    r.acc_out_y  = lane[4];
                    r.acc_out_z  = lane[5];
                    r.overflowed = dropped;
                    pending = {pending, r};
                end
                default: ;
            endcase
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report("unexpected result", 64'(got), 0);
                return;
            end
            want = pending.pop_front();
            if (got.rate_x !== want.rate_x) report("rate_x", got.rate_x, want.rate_x);
            if (got.rate_y !== want.rate_y) report("rate_y", got.rate_y, want.rate_y);
            if (got.rate_z !== want.rate_z) report("rate_z", got.rate_z, want.rate_z);
            if (got.acc_out_x !== want.acc_out_x)
                report("acc_out_x", got.acc_out_x, want.acc_out_x);
            if (got.acc_out_y !== want.acc_out_y)
                report("acc_out_y", got.acc_out_y, want.acc_out_y);
            if (got.acc_out_z !== want.acc_out_z)
                report("acc_out_z", got.acc_out_z, want.acc_out_z);
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.overflowed !== want.overflowed)
                report("overflowed", got.overflowed, want.overflowed);
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    resample_scoreboard sb = new();
    int idle_in  = 0;
    int idle_out = 0;
    int sent     = 0;

    imu_linear_interp_resampler_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);
        i_out_stall <= ($urandom_range(99) < idle_out);
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item make_item(logic [1:0] op, logic [47:0] stamp);
        t_in_item it;
        it.op      = op;
        it.stamp   = stamp;
        it.gyro_x  = pick_value();
        it.gyro_y  = pick_value();
        it.gyro_z  = pick_value();
        it.accel_x = pick_value();
        it.accel_y = pick_value();
        it.accel_z = pick_value();
        return it;
    endfunction

    // hold valid until the item is taken; drop it only while idling
    task send(t_in_item it);
        if ($urandom_range(99) < idle_in) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_in) @(posedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(it);
        if (it.op != OP_NOP) sent++;
    endtask

    task send_vals(logic [1:0] op, logic [47:0] stamp, logic [31:0] v);
        t_in_item it;
        it = make_item(op, stamp);
        {it.gyro_x, it.gyro_y, it.gyro_z} = {v, v, ~v};
        {it.accel_x, it.accel_y, it.accel_z} = {~v, v, ~v};
        send(it);
    endtask

    task run_batch(bit fill);
        longint      cur;
        longint      lo, hi;
        int          n, m;
        logic [47:0] smp[$];
        logic [47:0] qs[$];
        n   = fill ? DEPTH + $urandom_range(1, 4) : $urandom_range(1, 12);
        cur = longint'(48'({$urandom(), $urandom()}));
        if (cur < n * 1_100_000) cur = cur + n * 1_100_000;
        for (int i = 0; i < n; i++) begin
            smp = {smp, 48'(cur)};
            send(make_item(i == 0 ? OP_START : OP_APPEND, 48'(cur)));
            if ($urandom_range(29) == 0 && cur < 64'hFFFF_FFFF_0000)
                cur = cur + $urandom_range(1, 1000);    // out-of-order noise
            else if ($urandom_range(19) != 0)
                cur = cur - $urandom_range(1, 1_000_000);
        end
        hi = longint'(smp[0]) + 5000;
        if (hi > 64'hFFFF_FFFF_FFFF) hi = 64'hFFFF_FFFF_FFFF;
        lo = longint'(smp[smp.size() - 1]) - 5000;
        if (lo < 0) lo = 0;
        m = $urandom_range(1, 10);
        for (int i = 0; i < m; i++) begin
            if ($urandom_range(3) == 0)
                qs = {qs, smp[$urandom_range(smp.size() - 1)]};
            else
                qs = {qs, 48'(lo + longint'({$urandom(), $urandom()} % (hi - lo + 1)))};
        end
        if ($urandom_range(9) != 0) qs.rsort();
        else qs.shuffle();
        foreach (qs[i]) send(make_item(OP_QUERY, qs[i]));
        if ($urandom_range(15) == 0) send(make_item(OP_NOP, 48'({$urandom(), $urandom()})));
    endtask

    initial begin
        int batches;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, append without a start, unused op
        send_vals(OP_QUERY, 48'h1234, 32'h0);
        send_vals(OP_APPEND, 48'hFFFF_FFFF_FFFF, 32'h7fff_ffff);
        send_vals(OP_QUERY, 48'h0, 32'h0);
        send_vals(OP_NOP, 48'hFFFF_FFFF_FFFF, 32'hffff_ffff);
        // newest past, exact stamps, tiny fraction, equal neighbors
        send_vals(OP_START, 48'd2000, 32'h8000_0000);
        send_vals(OP_APPEND, 48'd1000, 32'h7fff_ffff);
        send_vals(OP_APPEND, 48'd1000, 32'h0);
        send_vals(OP_APPEND, 48'd0, 32'h5555_aaaa);
        send_vals(OP_QUERY, 48'hFFFF_FFFF_FFFF, 32'h0);
        send_vals(OP_QUERY, 48'd2000, 32'h0);
        send_vals(OP_QUERY, 48'd1999, 32'h0);
        send_vals(OP_QUERY, 48'd1500, 32'h0);
        send_vals(OP_QUERY, 48'd1002, 32'h0);
        send_vals(OP_QUERY, 48'd1001, 32'h0);
        send_vals(OP_QUERY, 48'd1000, 32'h0);
        send_vals(OP_QUERY, 48'd999, 32'h0);
        send_vals(OP_QUERY, 48'd0, 32'h0);
        send_vals(OP_QUERY, 48'd0, 32'h0);
        // pointer held: a later, newer query overshoots the bracket
        send_vals(OP_START, 48'd500, 32'h1);
        send_vals(OP_APPEND, 48'd100, 32'hffff_fffe);
        send_vals(OP_QUERY, 48'd200, 32'h0);
        send_vals(OP_QUERY, 48'd600, 32'h0);

        for (int ph = 0; ph < 3; ph++) begin
            idle_in  = (ph == 0) ? 35 : (ph == 1) ? 59 : 0;
            idle_out = (ph == 0) ? 59 : (ph == 1) ? 35 : 0;
            batches  = 0;
            while (sent < 22 + (ph + 1) * 333) begin
                run_batch(batches == 3);
                batches++;
            end
        end
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("timeout at %0t", $realtime);
        $display("== FAIL ==");
        $finish;
    end

endmodule
